FILE: sv/assert_macros.svh
// Assertion macros for the joystick axis conditioner.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/jac_pkg.sv
// Package for the joystick axis conditioner: sequencer states and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jac_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLEND,
        ST_NORM,
        ST_DIV,
        ST_ZONE,
        ST_COEF,
        ST_MAC,
        ST_ROUND,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_DEADZONE  = 3'd0;
    localparam logic [2:0] REG_ALIVEZONE = 3'd1;
    localparam logic [2:0] REG_CAL_ITER  = 3'd2;
    localparam logic [2:0] REG_CAL_WGT   = 3'd3;
    localparam logic [2:0] REG_ALPHA     = 3'd4;
    localparam logic [2:0] REG_INV_X     = 3'd5;
    localparam logic [2:0] REG_INV_Y     = 3'd6;

    localparam logic [11:0] OFFSET_RESET = 12'd2048;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
endpackage
`default_nettype wire

FILE: sv/joystick_axis_conditioner.sv
// Joystick axis conditioner: calibration, normalization, zones and FIR smoothing.
// Depends on jac_pkg and assert_macros.svh.
//
// Usage: one X/Y sample pair is a transfer on the input channel (i_valid/o_ready).
// A command of 1 restarts offset calibration before the sample is used. The block
// then works on the item alone and presents one result transfer on the output
// channel (o_valid/i_ready): filtered X and Y in Q1.15 and the calibrating flag.
// Each axis is handled in turn by one shared datapath: a restoring divider that
// retires one quotient bit per cycle and one multiplier that builds the coefficients
// and then walks the history taps. The divider is skipped when the sample equals
// the offset, and no new item is taken while one is in work.
// A finished result waits in the output register, so the next item is accepted
// while it waits. If the receiver stalls longer, the result holds and the next
// item waits in its last step with input not ready. Reset returns registers and
// state to their defaults and clears the history at once through per-entry valid
// bits. Configuration writes (i_cfg_valid/o_cfg_ready) are always taken and must
// only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module joystick_axis_conditioner #(
    parameter int TAPS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [11:0] i_x_sample,
    input  wire logic [11:0] i_y_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_x_value,
    output logic signed [15:0] o_y_value,
    output logic             o_calibrating,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import jac_pkg::*;
    `include "assert_macros.svh"

    localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;

    // Configuration registers.
    logic [14:0] r_deadzone;
    logic [15:0] r_alivezone;
    logic [15:0] r_cal_iter;
    logic [16:0] r_cal_wgt;
    logic [16:0] r_alpha;
    logic        r_inv_x, r_inv_y;

    // Axis state, index 0 is X, 1 is Y.
    logic [11:0] r_offset [2];
    logic [11:0] r_min [2];
    logic [11:0] r_max [2];
    logic signed [15:0] r_hist [2][TAPS];
    logic [TAPS-1:0] r_hvalid;
    logic [TW-1:0] r_slot;
    logic [15:0] r_cal_rem;
    logic        r_cal_active;

    // Sequencer and datapath registers.
    t_state r_state, n_state;
    logic        r_axis;
    logic        r_cmd;
    logic [11:0] r_samp [2];
    logic [4:0]  r_cnt;
    logic [27:0] r_rem;
    logic [11:0] r_den;
    logic [15:0] r_quo;
    logic        r_neg;
    logic        r_zero;
    logic signed [15:0] r_val;
    logic [16:0] r_coef [TAPS];
    logic [TW:0] r_tap;
    logic signed [40:0] r_acc;
    logic signed [15:0] r_res [2];
    logic        r_ovalid;
    logic signed [15:0] r_out_x, r_out_y;
    logic        r_out_cal;

    logic [16:0] w_wgt, w_alpha;
    assign w_wgt   = (r_cal_wgt > ONE_Q16) ? ONE_Q16 : r_cal_wgt;
    assign w_alpha = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;

    // The output register takes a finished result when it is empty or being drained.
    logic w_out_load;
    assign w_out_load = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_x_value     = r_out_x;
    assign o_y_value     = r_out_y;
    assign o_calibrating = r_out_cal;

    // Sample of the axis in work, and min/max updated by it.
    logic [11:0] w_s, w_mn, w_mx, w_off;
    assign w_s   = r_samp[r_axis];
    assign w_off = r_offset[r_axis];
    assign w_mn  = (w_s < r_min[r_axis]) ? w_s : r_min[r_axis];
    assign w_mx  = (w_s > r_max[r_axis]) ? w_s : r_max[r_axis];

    // One restoring divide step.
    logic [27:0] w_trial;
    logic        w_fit;
    assign w_fit   = r_rem[27:15] >= {1'b0, r_den};
    assign w_trial = w_fit ? {r_rem[27:15] - {1'b0, r_den}, r_rem[14:0]} : r_rem;

    // Coefficient step and tap product (the shared multiplier).
    logic [16:0]   w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [35:0] w_prod;
    logic signed [15:0] w_hval;
    // History slot of the current tap, wrapped by one compare and add.
    logic [TW:0]   w_hsum;
    logic [TW-1:0] w_hidx;
    assign w_hsum = {1'b0, r_slot} - r_tap
                  + ((r_tap > {1'b0, r_slot}) ? (TW+1)'(TAPS) : '0);
    assign w_hidx = w_hsum[TW-1:0];
    // The newest tap is the value just produced for this item.
    assign w_hval = (r_tap == '0) ? r_val
                  : (r_hvalid[w_hidx] ? r_hist[r_axis][w_hidx] : 16'sd0);
    always_comb begin
        if (r_state == ST_COEF) begin
            w_mul_a = r_coef[r_tap[TW-1:0] - TW'(1)];
            w_mul_b = 18'(ONE_Q16 - w_alpha);
        end else begin
            w_mul_a = r_coef[r_tap[TW-1:0]];
            w_mul_b = 18'(w_hval);
        end
    end
    assign w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

    // Rounding of the accumulated sum.
    logic [40:0] w_mag;
    logic [24:0] w_rnd;
    logic [15:0] w_sat;
    logic signed [15:0] w_fin;
    always_comb begin
        w_mag = r_acc[40] ? 41'(-r_acc) : 41'(r_acc);
        w_rnd = 25'((w_mag + 41'd32768) >> 16);
        w_sat = (w_rnd > 25'd32767) ? 16'd32767 : w_rnd[15:0];
        w_fin = r_acc[40] ? -$signed(w_sat) : $signed(w_sat);
        if (r_axis ? r_inv_y : r_inv_x) w_fin = -w_fin;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid && o_ready) n_state = ST_BLEND;
            ST_BLEND: n_state = ST_NORM;
            ST_NORM:  n_state = (w_s == w_off) ? ST_ZONE : ST_DIV;
            ST_DIV:   if (r_cnt == 5'd15) n_state = ST_ZONE;
            ST_ZONE:  n_state = (TAPS > 1) ? ST_COEF : ST_MAC;
            ST_COEF:  if (r_tap == (TW+1)'(TAPS - 1)) n_state = ST_MAC;
            ST_MAC:   if (r_tap == (TW+1)'(TAPS - 1)) n_state = ST_ROUND;
            ST_ROUND: n_state = r_axis ? ST_OUT : ST_NORM;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= 15'd1638;
            r_alivezone <= 16'd32768;
            r_cal_iter  <= 16'd0;
            r_cal_wgt   <= ONE_Q16;
            r_alpha     <= 17'd32768;
            r_inv_x     <= 1'b0;
            r_inv_y     <= 1'b0;
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                REG_DEADZONE:  r_deadzone  <= i_cfg_data[14:0];
                REG_ALIVEZONE: r_alivezone <= i_cfg_data[15:0];
                REG_CAL_ITER:  r_cal_iter  <= i_cfg_data[15:0];
                REG_CAL_WGT:   r_cal_wgt   <= i_cfg_data[16:0];
                REG_ALPHA:     r_alpha     <= i_cfg_data[16:0];
                REG_INV_X:     r_inv_x     <= i_cfg_data[0];
                REG_INV_Y:     r_inv_y     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_out_x      <= 16'sd0;
            r_out_y      <= 16'sd0;
            r_out_cal    <= 1'b0;
            r_cal_active <= 1'b0;
            r_cal_rem    <= 16'd0;
            r_slot       <= '0;
            r_hvalid     <= '0;
            r_axis       <= 1'b0;
            for (int a = 0; a < 2; a++) begin
                r_offset[a] <= OFFSET_RESET;
                r_min[a]    <= 12'd4095;
                r_max[a]    <= 12'd0;
            end
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_cmd     <= i_command;
                    r_samp[0] <= i_x_sample;
                    r_samp[1] <= i_y_sample;
                    r_axis    <= 1'b0;
                end
                ST_BLEND: begin
                    // Calibration count and offset blend for both axes.
                    if (r_cmd || r_cal_active) begin
                        if ((r_cmd ? r_cal_iter : r_cal_rem) != 16'd0) begin
                            r_cal_active <= 1'b1;
                            r_cal_rem <= (r_cmd ? r_cal_iter : r_cal_rem) - 16'd1;
                            for (int a = 0; a < 2; a++)
                                r_offset[a] <= 12'((35'(r_offset[a]) * 35'(ONE_Q16 - w_wgt)
                                    + 35'(r_samp[a]) * 35'(w_wgt)) >> 16);
                        end else begin
                            r_cal_active <= 1'b0;
                            r_cal_rem    <= 16'd0;
                        end
                    end
                end
                ST_NORM: begin
                    r_min[r_axis] <= w_mn;
                    r_max[r_axis] <= w_mx;
                    r_zero <= (w_s == w_off);
                    r_neg  <= (w_s < w_off);
                    r_den  <= (w_s > w_off) ? w_mx - w_off : w_off - w_mn;
                    r_rem  <= {1'b0, (w_s > w_off) ? w_s - w_off : w_off - w_s, 15'd0};
                    r_quo  <= 16'd0;
                    r_cnt  <= 5'd0;
                end
                ST_DIV: begin
                    // Numerator is delta shifted left by 15; feed zero bits.
                    r_rem <= {w_trial[26:0], 1'b0};
                    r_quo <= {r_quo[14:0], w_fit};
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_ZONE: begin
                    logic [15:0] mag;
                    mag = (r_quo > 16'd32767) ? 16'd32767 : r_quo;
                    if (r_zero || !(mag > {1'b0, r_deadzone} && mag < r_alivezone))
                        r_val <= 16'sd0;
                    else
                        r_val <= r_neg ? -$signed(mag) : $signed(mag);
                    r_hist[r_axis][r_slot] <= 16'sd0;
                    r_coef[0] <= w_alpha;
                    r_tap <= (TAPS > 1) ? (TW+1)'(1) : '0;
                    r_acc <= '0;
                end
                ST_COEF: begin
                    r_coef[r_tap[TW-1:0]] <= w_prod[32:16];
                    if (r_tap == (TW+1)'(TAPS - 1)) r_tap <= '0;
                    else r_tap <= r_tap + (TW+1)'(1);
                    r_hist[r_axis][r_slot] <= r_val;
                    r_hvalid[r_slot] <= 1'b1;
                end
                ST_MAC: begin
                    r_hist[r_axis][r_slot] <= r_val;
                    r_hvalid[r_slot] <= 1'b1;
                    r_acc <= r_acc + 41'(w_prod);
                    r_tap <= r_tap + (TW+1)'(1);
                end
                ST_ROUND: begin
                    r_res[r_axis] <= w_fin;
                    r_axis <= 1'b1;
                    if (r_axis) begin
                        r_slot <= (r_slot == TW'(TAPS - 1)) ? '0 : r_slot + TW'(1);
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_out_x   <= r_res[0];
                        r_out_y   <= r_res[1];
                        r_out_cal <= r_cal_active;
                    end
                end
                default: ;
            endcase
        end
    end

    // Checks.
    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready, "busy but ready")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_x_value), "result lost")
    `CHK_IMPL(a_div_count, i_clk, i_rst_n, r_state == ST_DIV, r_cnt < 5'd16, "divider overran")
endmodule
`default_nettype wire

FILE: tb/jac_checker.sv
// Checker for the joystick axis conditioner: watches the sample, result and register channels.
// It keeps its own model of offsets, spans, history and filter, and counts mismatches.
// Depends on jac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jac_checker #(
    parameter int TAPS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_ready_in,
    input  wire logic               i_command,
    input  wire logic [11:0]        i_x_sample,
    input  wire logic [11:0]        i_y_sample,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [15:0] i_x_value,
    input  wire logic signed [15:0] i_y_value,
    input  wire logic               i_calibrating,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    import jac_pkg::*;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               calibrating;
    } t_position;

    // Register copies.
    logic [14:0] deadzone;
    logic [15:0] alivezone;
    logic [15:0] cal_iterations;
    logic [16:0] cal_weight;
    logic [16:0] filter_alpha;
    logic        invert_x, invert_y;

    // Axis state, index 0 is X and 1 is Y.
    logic [11:0]        offset[2];
    logic [11:0]        minimum[2];
    logic [11:0]        maximum[2];
    logic signed [15:0] history[2][TAPS];
    logic [15:0]        cal_remaining;
    logic               cal_active;
    int                 write_slot;

    t_position expected_positions[$];

    function automatic logic [16:0] clamp_q16(input logic [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    // Min/max tracking, normalization and zones for one axis.
    function automatic logic signed [15:0] condition_axis(input int ax, input logic [11:0] s);
        int delta;
        longint num, den, mag;
        if (s < minimum[ax]) minimum[ax] = s;
        if (s > maximum[ax]) maximum[ax] = s;
        delta = int'(s) - int'(offset[ax]);
        if (delta == 0) return 16'sd0;
        if (delta > 0) begin
            num = delta;
            den = longint'(maximum[ax]) - longint'(offset[ax]);
        end else begin
            num = -delta;
            den = longint'(offset[ax]) - longint'(minimum[ax]);
        end
        if (den <= 0) return 16'sd0;
        mag = (num << 15) / den;
        if (mag > 32767) mag = 32767;
        if (!(mag > deadzone && mag < alivezone)) return 16'sd0;
        return (delta > 0) ? 16'(mag) : 16'(-mag);
    endfunction

    // Exponential-weight FIR over the history, newest first.
    function automatic logic signed [15:0] smooth_axis(input int ax, input logic inv);
        longint coef, a, sum, m;
        int idx;
        a = clamp_q16(filter_alpha);
        coef = a;
        sum = 0;
        for (int i = 0; i < TAPS; i++) begin
            if (i > 0) coef = (coef * (65536 - a)) >>> 16;
            idx = (write_slot + TAPS - i) % TAPS;
            sum += longint'(history[ax][idx]) * coef;
        end
        m = (sum < 0) ? -sum : sum;
        m = (m + 32768) >>> 16;
        if (m > 32767) m = 32767;
        if (sum < 0) m = -m;
        if (inv) m = -m;
        return 16'(m);
    endfunction

    task automatic predict_position(input logic cmd, input logic [11:0] xs,
                                    input logic [11:0] ys);
        t_position p;
        longint w;
        if (cmd) begin
            cal_remaining = cal_iterations;
            cal_active = 1'b1;
        end
        if (cal_active && cal_remaining > 0) begin
            w = clamp_q16(cal_weight);
            offset[0] = 12'((longint'(offset[0]) * (65536 - w) + longint'(xs) * w) >> 16);
            offset[1] = 12'((longint'(offset[1]) * (65536 - w) + longint'(ys) * w) >> 16);
            cal_remaining = cal_remaining - 16'd1;
        end else if (cal_active) begin
            cal_active = 1'b0;
        end
        history[0][write_slot] = condition_axis(0, xs);
        history[1][write_slot] = condition_axis(1, ys);
        p.x_value = smooth_axis(0, invert_x);
        p.y_value = smooth_axis(1, invert_y);
        p.calibrating = cal_active;
        write_slot = (write_slot + 1) % TAPS;
        expected_positions.push_back(p);
    endtask

    assign o_pending = expected_positions.size();

    always @(posedge i_clk) begin
        t_position e;
        if (!i_rst_n) begin
            deadzone = 15'd1638;
            alivezone = 16'd32768;
            cal_iterations = 16'd0;
            cal_weight = 17'd65536;
            filter_alpha = 17'd32768;
            invert_x = 1'b0;
            invert_y = 1'b0;
            for (int ax = 0; ax < 2; ax++) begin
                offset[ax] = OFFSET_RESET;
                minimum[ax] = 12'd4095;
                maximum[ax] = 12'd0;
                for (int i = 0; i < TAPS; i++) history[ax][i] = 16'sd0;
            end
            cal_remaining = 16'd0;
            cal_active = 1'b0;
            write_slot = 0;
            expected_positions.delete();
            o_fail_count = 0;
        end else begin
            // Register write transfer.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEADZONE:  deadzone = i_cfg_data[14:0];
                    REG_ALIVEZONE: alivezone = i_cfg_data[15:0];
                    REG_CAL_ITER:  cal_iterations = i_cfg_data[15:0];
                    REG_CAL_WGT:   cal_weight = i_cfg_data[16:0];
                    REG_ALPHA:     filter_alpha = i_cfg_data[16:0];
                    REG_INV_X:     invert_x = i_cfg_data[0];
                    REG_INV_Y:     invert_y = i_cfg_data[0];
                    default: ;
                endcase
            end
            // Result transfer is checked against the oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", i_x_value, i_y_value);
                    o_fail_count++;
                end else begin
                    e = expected_positions.pop_front();
                    if (i_x_value !== e.x_value) begin
                        $error("x_value expected %0d actual %0d", e.x_value, i_x_value);
                        o_fail_count++;
                    end
                    if (i_y_value !== e.y_value) begin
                        $error("y_value expected %0d actual %0d", e.y_value, i_y_value);
                        o_fail_count++;
                    end
                    if (i_calibrating !== e.calibrating) begin
                        $error("calibrating expected %0d actual %0d", e.calibrating,
                               i_calibrating);
                        o_fail_count++;
                    end
                end
            end
            // Sample transfer.
            if (i_valid && i_ready_in) predict_position(i_command, i_x_sample, i_y_sample);
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb_joystick_axis_conditioner.sv
// Testbench top for the joystick axis conditioner: clock, reset, stimulus and verdict.
// Depends on jac_pkg, jac_checker and the block itself.
`timescale 1ns / 1ps
`default_nettype none
module tb_joystick_axis_conditioner;
    import jac_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_command = 1'b0;
    logic [11:0]        i_x_sample = '0;
    logic [11:0]        i_y_sample = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_x_value, o_y_value;
    logic               o_calibrating;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    int                 fail_count, pending;
    bit                 hold_off = 1'b0;
    bit                 no_gaps = 1'b0;
    int                 quiet_cycles = 0;

    joystick_axis_conditioner u_dut (.*);

    jac_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_command(i_command),
        .i_x_sample(i_x_sample), .i_y_sample(i_y_sample),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_x_value(o_x_value), .i_y_value(o_y_value), .i_calibrating(o_calibrating),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stalls per result, plus an optional long hold-off.
    initial begin
        int wait_cycles;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
            end else if (!i_ready) begin
                wait_cycles = no_gaps ? 0 : $urandom_range(0, 11);
                repeat (wait_cycles) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (o_valid) begin
                // This edge took a result; draw the stall before the next one.
                if (!no_gaps && $urandom_range(0, 11) != 0) i_ready <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic cmd, input logic [11:0] xs, input logic [11:0] ys);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_x_sample <= xs;
        i_y_sample <= ys;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small moves around center with occasional full-range reads.
    function automatic logic [11:0] random_reading();
        if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(1500, 2600));
    endfunction

    task automatic random_settings();
        write_register(REG_DEADZONE, $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 4000));
        write_register(REG_ALIVEZONE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                 : $urandom_range(20000, 32768));
        write_register(REG_CAL_ITER, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 12));
        write_register(REG_CAL_WGT, $urandom_range(0, 131071));
        write_register(REG_ALPHA, $urandom_range(0, 4) == 0 ? $urandom_range(0, 131071)
                                                             : $urandom_range(0, 65536));
        write_register(REG_INV_X, $urandom);
        write_register(REG_INV_Y, $urandom);
    endtask

    initial begin
        logic [11:0] edge_values[6] = '{12'd0, 12'd4095, 12'd2048, 12'd2047, 12'd2049, 12'hAAA};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero delta, full-scale extremes, calibration with zero count.
        send_sample(1'b0, 12'd2048, 12'd2048);
        foreach (edge_values[k]) send_sample(1'b0, edge_values[k], edge_values[5 - k]);
        send_sample(1'b1, 12'd1000, 12'd3000);
        send_sample(1'b0, 12'd0, 12'd4095);
        drain_results();

        // Extreme settings: calibration with over-range weight, restart mid-run.
        write_register(REG_DEADZONE, 32'd0);
        write_register(REG_ALIVEZONE, 32'd65535);
        write_register(REG_CAL_ITER, 32'd3);
        write_register(REG_CAL_WGT, 32'h1FFFF);
        write_register(REG_ALPHA, 32'h1FFFF);
        write_register(REG_INV_X, 32'd1);
        write_register(REG_INV_Y, 32'd1);
        write_register(3'd7, 32'hFFFF_FFFF);
        send_sample(1'b1, 12'd2100, 12'd1900);
        send_sample(1'b0, 12'd4095, 12'd0);
        send_sample(1'b1, 12'd2200, 12'd1800);
        for (int i = 0; i < 5; i++) send_sample(1'b0, 12'hFFF, 12'h555);
        drain_results();
        write_register(REG_ALPHA, 32'd0);
        write_register(REG_DEADZONE, 32'd32767);
        write_register(REG_CAL_WGT, 32'd0);
        send_sample(1'b1, 12'd3000, 12'd100);
        send_sample(1'b0, 12'd100, 12'd3000);
        drain_results();

        // Random phases, each under fresh settings.
        for (int phase = 0; phase < 10; phase++) begin
            random_settings();
            no_gaps = (phase == 3);
            for (int n = 0; n < 53; n++) begin
                if (phase == 5 && n == 10) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (300) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (phase == 7 && n == 20) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_sample($urandom_range(0, 15) == 0, random_reading(), random_reading());
            end
            no_gaps = 1'b0;
            drain_results();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
